// ----- rtl/core/aht_pkg.sv -----
package aht_pkg;

  // Default geometry of the table
  localparam int unsigned DefNumBuckets = 1024;
  localparam int unsigned DefWays       = 4;

  // Field widths
  localparam int unsigned AddrW  = 64;
  localparam int unsigned PidW   = 32;
  localparam int unsigned CpuW   = 8;
  localparam int unsigned CountW = 32;
  localparam int unsigned TotalW = 48;

  // Bucket hash: (address >> AddrShift) mod NUM_BUCKETS, folded MSB first,
  // HashStep bits per chunk, two steps per chunk (estimate, then correct)
  localparam int unsigned AddrShift  = 3;
  localparam int unsigned HashBits   = 64;
  localparam int unsigned HashStep   = 16;
  localparam int unsigned HashChunks = HashBits / HashStep;
  localparam int unsigned HashCycles = 2 * HashChunks;
  localparam int unsigned HashCntW   = $clog2(HashCycles + 1);

  localparam int unsigned ModeGet = 1;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] address;
    logic [PidW-1:0]  pid;
    logic [CpuW-1:0]  cpu_id;
  } aht_in_t;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] hits_for_address;
    logic [PidW-1:0]   owner_pid;
    logic [CpuW-1:0]   owner_cpu;
    logic              dropped;
    logic [TotalW-1:0] total_samples;
  } aht_out_t;

  // One slot of a bucket row in the table memory
  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  key;
    logic [CountW-1:0] count;
    logic [PidW-1:0]   pid;
    logic [CpuW-1:0]   cpu;
  } aht_slot_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP
  } aht_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr;        // write an empty row at the sweep address
    logic capture;    // latch the accepted word
    logic hash_step;  // advance the bucket reduction
    logic rd_en;      // read the bucket row
    logic commit;     // write back, update total, load the result
  } aht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic fast_idx;
    logic hash_done;
    logic out_busy;
  } aht_sts_t;

endpackage

// ----- rtl/core/aht_stream_if.sv -----
interface aht_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/aht_ram.sv -----
module aht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/aht_ctrl.sv -----
module aht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aht_pkg::aht_sts_t sts_i,
  output aht_pkg::aht_cmd_t cmd_o
);
  import aht_pkg::*;

  aht_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.fast_idx) begin
            cmd_o.rd_en = 1'b1;
            state_d     = ST_LOOKUP;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_LOOKUP;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      ST_LOOKUP: begin
        // hold the row until the result register is free
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_commit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.out_busy)
    else $error("commit while result register is occupied");
`endif
endmodule

// ----- rtl/core/aht_dpath.sv -----
module aht_dpath #(
  parameter int unsigned NUM_BUCKETS = aht_pkg::DefNumBuckets,
  parameter int unsigned WAYS        = aht_pkg::DefWays
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aht_pkg::aht_cmd_t cmd_i,
  output aht_pkg::aht_sts_t sts_o,
  input  aht_pkg::aht_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aht_pkg::aht_out_t out_item_o
);
  import aht_pkg::*;

  localparam int unsigned IW     = $clog2(NUM_BUCKETS);
  localparam int unsigned WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RowW   = WAYS * $bits(aht_slot_t);
  localparam bit          IsPow2 = (NUM_BUCKETS == (1 << IW));
  // floor(2^32 / NUM_BUCKETS): quotient estimate is exact or one short
  localparam logic [31:0] RecipM = 32'((64'd1 << 32) / NUM_BUCKETS);
  localparam logic [31:0] NumB32 = 32'(NUM_BUCKETS);

  aht_in_t               item_q;
  logic [HashBits-1:0]   sh_q;
  logic [IW-1:0]         rem_q, rem_d;
  logic [31:0]           fold_v, fold_vq, fold_r;
  logic [63:0]           fold_p, fold_pq;
  logic [HashCntW-1:0]   hcnt_q;
  logic [IW-1:0]         clr_q;
  logic [TotalW-1:0]     total_q;
  logic                  out_valid_q;
  aht_out_t              out_q;

  logic [IW-1:0]         raddr, baddr, waddr;
  logic                  we;
  logic [RowW-1:0]       wdata, rdata;
  aht_slot_t [WAYS-1:0]  row_rd, row_wr;
  logic                  hit, has_free, is_put, do_count;
  logic [WW-1:0]         hit_way, free_way;
  logic [CountW-1:0]     new_count;
  aht_slot_t             hit_slot;
  aht_out_t              res;

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // Fold the next HashStep address bits into the remainder: estimate the
  // quotient by reciprocal multiplication, then correct by one subtract
  assign fold_v = 32'({rem_q, sh_q[HashBits-1 -: HashStep]});
  assign fold_p = 64'(fold_v) * 64'(RecipM);
  assign fold_r = fold_vq - fold_pq[63:32] * NumB32;
  assign rem_d  = (fold_r >= NumB32) ? IW'(fold_r - NumB32) : IW'(fold_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
    end else if (cmd_i.capture) begin
      hcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hcnt_q <= hcnt_q + 1'b1;
    end
  end

  // Even steps estimate, odd steps correct and advance to the next chunk
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sh_q  <= HashBits'(in_item_i.address >> AddrShift);
      rem_q <= '0;
    end else if (cmd_i.hash_step) begin
      if (!hcnt_q[0]) begin
        fold_vq <= fold_v;
        fold_pq <= fold_p;
      end else begin
        rem_q <= rem_d;
        sh_q  <= sh_q << HashStep;
      end
    end
  end

  // Bucket addresses: direct bits for a power-of-two table, else the remainder
  assign raddr = IsPow2 ? in_item_i.address[IW+AddrShift-1:AddrShift] : rem_q;
  assign baddr = IsPow2 ? item_q.address[IW+AddrShift-1:AddrShift] : rem_q;

  // Sweep counter for the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  aht_ram #(
    .WIDTH (RowW),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign row_rd = rdata;

  // Find the first matching way and the first free way
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd[w].valid && row_rd[w].key == item_q.address) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
      if (!row_rd[w].valid) begin
        has_free = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  assign hit_slot  = row_rd[hit_way];
  assign is_put    = (item_q.mode != 1'(ModeGet));
  assign do_count  = is_put && (hit || has_free);
  assign new_count = (&hit_slot.count) ? hit_slot.count : hit_slot.count + 1'b1;

  // Build the write-back row and the result word
  always_comb begin
    row_wr = row_rd;
    res    = '0;
    res.total_samples = total_q;
    if (hit) begin
      res.hit       = 1'b1;
      res.owner_pid = hit_slot.pid;
      res.owner_cpu = hit_slot.cpu;
      if (is_put) begin
        row_wr[hit_way].count = new_count;
        res.hits_for_address  = new_count;
      end else begin
        res.hits_for_address = hit_slot.count;
      end
    end else if (is_put && has_free) begin
      row_wr[free_way].valid = 1'b1;
      row_wr[free_way].key   = item_q.address;
      row_wr[free_way].count = CountW'(1);
      row_wr[free_way].pid   = item_q.pid;
      row_wr[free_way].cpu   = item_q.cpu_id;
      res.hits_for_address   = CountW'(1);
      res.owner_pid          = item_q.pid;
      res.owner_cpu          = item_q.cpu_id;
    end else if (is_put) begin
      res.dropped = 1'b1;
    end
    if (do_count && !(&total_q)) begin
      res.total_samples = total_q + 1'b1;
    end
  end

  assign we    = cmd_i.clr || (cmd_i.commit && do_count);
  assign waddr = cmd_i.clr ? clr_q : baddr;
  assign wdata = cmd_i.clr ? '0 : RowW'(row_wr);

  // Running total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.commit) begin
      total_q <= res.total_samples;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;
  assign sts_o.clr_last  = (clr_q == IW'(NUM_BUCKETS - 1));
  assign sts_o.fast_idx  = IsPow2;
  assign sts_o.hash_done = (hcnt_q == HashCntW'(HashCycles));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

`ifndef ASSERT_OFF
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");
  a_put_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && do_count && !(&total_q)) |=> total_q == $past(total_q) + 1'b1)
    else $error("counted put did not raise the total");
  a_get_keeps_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !is_put) |=> $stable(total_q))
    else $error("lookup changed the total");
  a_get_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && !cmd_i.clr) |-> (cmd_i.commit && is_put))
    else $error("table written outside a put");
`endif
endmodule

// ----- rtl/core/address_hit_count_table.sv -----
// Per-address sample counter. Each accepted word looks up its 64-bit address in
// bucket (address >> 3) mod NUM_BUCKETS, WAYS slots per bucket, held as one row
// of a single-port-write, registered-read memory. A put bumps the matching
// count or claims the lowest free way; a get only reports. Exactly one result
// word comes out per input word, held in an output register so the next word
// can be taken while a result waits. For a power-of-two NUM_BUCKETS the row
// is read as the word is accepted, then compared and written back in the
// lookup state; otherwise a remainder unit ahead of the row read, folding 16
// address bits at a time by reciprocal multiplication (8 steps, then the read
// is issued), gives the bucket index. A stalled output holds back compare
// and write-back until the result register is free. After reset the block
// sweeps the memory, one row per cycle, clearing all NUM_BUCKETS rows before it
// takes the first word. Counts saturate at 2^32-1, the running total at 2^48-1.
module address_hit_count_table #(
  parameter int unsigned NUM_BUCKETS = aht_pkg::DefNumBuckets,
  parameter int unsigned WAYS        = aht_pkg::DefWays
) (
  input logic         clk_i,
  input logic         rst_ni,
  aht_stream_if.sink   in_i,
  aht_stream_if.source out_o
);
  import aht_pkg::*;

  aht_cmd_t cmd;
  aht_sts_t sts;

  aht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aht_dpath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_i.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import aht_pkg::*;

  localparam int unsigned NumBuckets  = DefNumBuckets;
  localparam int unsigned Ways        = DefWays;
  localparam int unsigned Slots       = NumBuckets * Ways;
  localparam int unsigned BucketBits  = $clog2(NumBuckets);
  localparam int unsigned NumHot      = 12;
  localparam int unsigned RandItems   = 600;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 200000;

  localparam logic OpPut = 1'b0;
  localparam logic OpGet = 1'(ModeGet);

  typedef enum int {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_TOGGLE
  } ready_mode_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     drv_valid = 1'b0;
  aht_in_t  drv_word = '0;
  logic     rcv_ready = 1'b0;

  aht_stream_if #(.payload_t(aht_in_t))  in_if ();
  aht_stream_if #(.payload_t(aht_out_t)) out_if ();

  assign in_if.valid   = drv_valid;
  assign in_if.payload = drv_word;
  assign out_if.ready  = rcv_ready;

  address_hit_count_table #(
    .NUM_BUCKETS(NumBuckets),
    .WAYS       (Ways)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow copy of the table and the running total
  bit                tbl_valid [Slots];
  logic [AddrW-1:0]  tbl_key   [Slots];
  logic [CountW-1:0] tbl_count [Slots];
  logic [PidW-1:0]   tbl_pid   [Slots];
  logic [CpuW-1:0]   tbl_cpu   [Slots];
  logic [TotalW-1:0] tbl_total = '0;

  aht_in_t     sample_q[$];
  aht_out_t    table_result_q[$];
  logic [63:0] seen_addr_q[$];
  int unsigned hot_bkt [NumHot];

  int unsigned n_items;
  int unsigned taken_cnt;
  int unsigned seen_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned phase_left;
  ready_mode_e phase_kind;
  aht_out_t    due_word;

  // Look the word up in the shadow table, update it, and return the result word
  function automatic aht_out_t lookup_and_count(aht_in_t w);
    logic [63:0] bkt;
    int          base;
    int          hit_slot;
    int          free_slot;
    int          s;
    aht_out_t    r;
    r         = '0;
    bkt       = (w.address >> AddrShift) % NumBuckets;
    base      = int'(bkt) * Ways;
    hit_slot  = -1;
    free_slot = -1;
    for (int way = 0; way < Ways; way++) begin
      s = base + way;
      if (tbl_valid[s] && tbl_key[s] == w.address) begin
        if (hit_slot < 0) hit_slot = s;
      end else if (!tbl_valid[s] && free_slot < 0) begin
        free_slot = s;
      end
    end
    if (hit_slot >= 0) begin
      if (w.mode == OpPut) begin
        if (tbl_count[hit_slot] != '1) tbl_count[hit_slot]++;
        if (tbl_total != '1) tbl_total++;
      end
      r.hit              = 1'b1;
      r.hits_for_address = tbl_count[hit_slot];
      r.owner_pid        = tbl_pid[hit_slot];
      r.owner_cpu        = tbl_cpu[hit_slot];
    end else if (w.mode == OpGet) begin
      // miss: all entry fields stay zero
    end else if (free_slot < 0) begin
      r.dropped = 1'b1;
    end else begin
      // claim the lowest free way
      tbl_valid[free_slot] = 1'b1;
      tbl_key[free_slot]   = w.address;
      tbl_count[free_slot] = 1;
      tbl_pid[free_slot]   = w.pid;
      tbl_cpu[free_slot]   = w.cpu_id;
      if (tbl_total != '1) tbl_total++;
      r.hits_for_address = 1;
      r.owner_pid        = w.pid;
      r.owner_cpu        = w.cpu_id;
    end
    r.total_samples = tbl_total;
    return r;
  endfunction

  function automatic logic [63:0] addr_in_bucket(int unsigned bkt, logic [63:0] high,
                                                 logic [2:0] low);
    return (high << (AddrShift + BucketBits)) | (64'(bkt) << AddrShift) | 64'(low);
  endfunction

  task automatic add_sample(logic mode, logic [63:0] addr, logic [31:0] pid,
                            logic [7:0] cpu);
    aht_in_t w;
    w.mode    = mode;
    w.address = addr;
    w.pid     = pid;
    w.cpu_id  = cpu;
    sample_q.push_back(w);
    seen_addr_q.push_back(addr);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // Build the word list, release reset, wait for the last result
  initial begin
    logic [63:0] a7;
    logic [63:0] addr;
    int unsigned pick;

    // empty table, both extremes of address, pid and cpu
    add_sample(OpGet, 64'h0, '1, '1);
    add_sample(OpPut, 64'h0, '0, '0);
    add_sample(OpPut, 64'h0, '1, '1);
    add_sample(OpGet, 64'h0, '1, '1);
    add_sample(OpPut, '1, '1, '1);
    add_sample(OpGet, '1, '0, '0);
    // same bucket as address zero, different key
    add_sample(OpGet, 64'h1, '0, '0);
    add_sample(OpPut, 64'h1, 32'h1234_5678, 8'h5a);
    // fill one bucket, then overflow it
    a7 = addr_in_bucket(7, 64'h0, 3'd0);
    add_sample(OpPut, a7, 32'h0000_0001, 8'h01);
    add_sample(OpPut, a7 | 64'h1, 32'h8000_0000, 8'h80);
    add_sample(OpPut, a7 | (64'h1 << 63), 32'hffff_fffe, 8'hfe);
    add_sample(OpPut, addr_in_bucket(7, 64'h5555_5555_5555, 3'd7), 32'hdead_beef, 8'h7f);
    add_sample(OpPut, addr_in_bucket(7, 64'h2aaa_aaaa_aaaa, 3'd3), 32'h0bad_cafe, 8'h33);
    add_sample(OpGet, addr_in_bucket(7, 64'h2aaa_aaaa_aaaa, 3'd3), '0, '0);
    add_sample(OpPut, a7 | (64'h1 << 63), '0, '0);
    add_sample(OpGet, a7, '0, '0);
    add_sample(OpPut, addr_in_bucket(7, 64'h2aaa_aaaa_aaaa, 3'd3), '1, '1);
    // another bucket with two keys that differ only above the index
    add_sample(OpPut, 64'h8, 32'h1111_1111, 8'h11);
    add_sample(OpPut, 64'h8 + 64'(NumBuckets) * 8, 32'h2222_2222, 8'h22);
    add_sample(OpPut, 64'h8, '0, '0);
    add_sample(OpGet, 64'h8 + 64'(NumBuckets) * 8, '0, '0);

    // random words: reuse known keys, crowd a few hot buckets, sprinkle noise
    for (int i = 0; i < NumHot; i++) hot_bkt[i] = $urandom_range(0, NumBuckets - 1);
    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        addr = seen_addr_q[$urandom_range(0, seen_addr_q.size() - 1)];
      end else if (pick <= 7) begin
        addr = addr_in_bucket(hot_bkt[$urandom_range(0, NumHot - 1)],
                              {$urandom, $urandom}, 3'($urandom));
      end else begin
        addr = {$urandom, $urandom};
      end
      add_sample(($urandom_range(0, 9) < 7) ? OpPut : OpGet, addr, $urandom,
                 8'($urandom_range(0, 255)));
    end
    n_items = sample_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (taken_cnt != n_items || table_result_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Input driver: bursts of words with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      // predict on acceptance
      if (drv_valid && in_if.ready) begin
        table_result_q.push_back(lookup_and_count(drv_word));
        taken_cnt++;
      end
      // advance only when the current word is gone
      if (!drv_valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          drv_word  <= sample_q.pop_front();
          drv_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern and two long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_if.valid && rcv_ready) begin
        if (table_result_q.size() == 0) begin
          report_mismatch("result word with none expected");
        end else begin
          due_word = table_result_q.pop_front();
          check_field("hit", 64'(out_if.payload.hit), 64'(due_word.hit));
          check_field("hits_for_address", 64'(out_if.payload.hits_for_address),
                      64'(due_word.hits_for_address));
          check_field("owner_pid", 64'(out_if.payload.owner_pid), 64'(due_word.owner_pid));
          check_field("owner_cpu", 64'(out_if.payload.owner_cpu), 64'(due_word.owner_cpu));
          check_field("dropped", 64'(out_if.payload.dropped), 64'(due_word.dropped));
          check_field("total_samples", 64'(out_if.payload.total_samples),
                      64'(due_word.total_samples));
        end
        seen_cnt++;
        if (seen_cnt == 100 || seen_cnt == 400) hold_left = HoldCycles;
      end
      // hold off long enough for the block to back up into its input
      if (hold_left != 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_kind = ready_mode_e'($urandom_range(0, 3));
          phase_left = $urandom_range(10, 80);
        end
        phase_left--;
        case (phase_kind)
          RDY_ALWAYS: rcv_ready <= 1'b1;
          RDY_MOSTLY: rcv_ready <= ($urandom_range(0, 3) != 0);
          RDY_RARELY: rcv_ready <= ($urandom_range(0, 3) == 0);
          default:    rcv_ready <= ~rcv_ready;
        endcase
      end
    end
  end

endmodule
